// ===== design/rtdi_pkg.sv =====
package rtdi_pkg;

    localparam int unsigned CLASS_W   = 2;
    localparam int unsigned BRAKE_W   = 14;
    localparam int unsigned HOLD_W    = 16;
    localparam int unsigned NOW_W     = 32;
    localparam int unsigned CHIME_W   = 2;
    localparam int unsigned S_DATA_W  = 56;
    localparam int unsigned M_DATA_W  = 8;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [BRAKE_W-1:0] BRAKE_THRESHOLD_RESET = 14'd1000;
    localparam logic [HOLD_W-1:0]  HOLD_TIME_RESET       = 16'd1000;

    typedef enum logic [CLASS_W-1:0] {
        CLASS_OTHER     = 2'd0,
        CLASS_ENERGIZED = 2'd1,
        CLASS_DRIVE     = 2'd2,
        CLASS_UNUSED    = 2'd3
    } bms_class_t;

    typedef enum logic [CHIME_W-1:0] {
        CHIME_NONE  = 2'd0,
        CHIME_ENTER = 2'd1,
        CHIME_EXIT  = 2'd2,
        CHIME_RSVD  = 2'd3
    } chime_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BRAKE_THRESHOLD = 1'b0,
        REG_HOLD_TIME       = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [NOW_W-1:0]   now_ms;
        logic               bms_fresh;
        logic               brake_fresh;
        logic [BRAKE_W-1:0] brake_level;
        logic               button_pressed;
        bms_class_t         bms_class;
    } in_item_t;

    typedef struct packed {
        chime_t toggle_chime;
        chime_t transition_chime;
        logic   ready_to_drive;
    } out_item_t;

    typedef struct packed {
        logic [BRAKE_W-1:0] brake_threshold;
        logic [HOLD_W-1:0]  hold_time_ms;
    } cfg_t;

endpackage

// ===== design/ready_to_drive_interlock.sv =====
// Ready-to-drive interlock, one result item for every input item.
// Each item passes the input register, then the result register, which drives m_tvalid.
// Throughput: one item per cycle unless m_tready stalls the output; the state update is a
// single compare-and-flag pass between the input register and the result register.
// Reset (aresetn low, synchronous): both channels empty, interlock state cleared,
// brake_threshold and hold_time_ms back to 1000.
module ready_to_drive_interlock #(
    parameter int unsigned TIME_BITS = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // bms_class[1:0], button_pressed[2], brake_level[16:3], brake_fresh[17],
    // bms_fresh[18], now_ms[50:19], zero fill [55:51]
    input  logic [rtdi_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // ready_to_drive[0], transition_chime[2:1], toggle_chime[4:3], zero fill [7:5]
    output logic [rtdi_pkg::M_DATA_W-1:0]   m_tdata,
    input  logic                            cfg_wr_en,
    input  logic [rtdi_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [rtdi_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import rtdi_pkg::*;

    localparam int unsigned ITEM_W = $bits(in_item_t);
    localparam int unsigned RES_W  = $bits(out_item_t);

    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;
    out_item_t result;
    cfg_t      cfg;
    logic      advance;
    logic      step;

    // The result register frees up whenever it is empty or being drained.
    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    rtdi_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    rtdi_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg <= in_item_t'(s_tdata[ITEM_W-1:0]);
        end
        if (step) begin
            out_item_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W-RES_W){1'b0}}, out_item_reg};

endmodule

// ===== design/rtdi_cfg.sv =====
module rtdi_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [rtdi_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [rtdi_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output rtdi_pkg::cfg_t                cfg
);
    import rtdi_pkg::*;

    logic [BRAKE_W-1:0] brake_threshold_reg;
    logic [HOLD_W-1:0]  hold_time_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            brake_threshold_reg <= BRAKE_THRESHOLD_RESET;
            hold_time_reg       <= HOLD_TIME_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_addr))
                REG_BRAKE_THRESHOLD: brake_threshold_reg <= cfg_wdata[BRAKE_W-1:0];
                REG_HOLD_TIME:       hold_time_reg       <= cfg_wdata[HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.brake_threshold = brake_threshold_reg;
    assign cfg.hold_time_ms    = hold_time_reg;

endmodule

// ===== design/rtdi_core.sv =====
module rtdi_core #(
    parameter int unsigned TIME_BITS = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  rtdi_pkg::in_item_t  item,
    input  rtdi_pkg::cfg_t      cfg,
    output rtdi_pkg::out_item_t result
);
    import rtdi_pkg::*;

    typedef logic [TIME_BITS-1:0] tick_t;

    bms_class_t prev_class_reg, prev_class_next;
    logic       ready_reg, ready_next;
    logic       armed_reg, armed_next;
    logic       latched_reg, latched_next;
    tick_t      arm_start_reg, arm_start_next;

    tick_t      now_t;
    tick_t      elapsed;
    logic       active;
    logic       arm_cond;
    logic       held;

    assign now_t    = TIME_BITS'(item.now_ms);
    assign active   = (item.bms_class == CLASS_ENERGIZED) || (item.bms_class == CLASS_DRIVE);
    assign arm_cond = item.brake_fresh && item.bms_fresh && item.button_pressed
                      && (item.brake_level > cfg.brake_threshold);

    always_comb begin
        prev_class_next = item.bms_class;
        ready_next      = ready_reg;
        armed_next      = armed_reg;
        latched_next    = latched_reg;
        arm_start_next  = arm_start_reg;
        elapsed         = '0;
        held            = 1'b0;
        result.transition_chime = CHIME_NONE;
        result.toggle_chime     = CHIME_NONE;

        if (prev_class_reg == CLASS_ENERGIZED && item.bms_class == CLASS_DRIVE) begin
            result.transition_chime = CHIME_ENTER;
        end else if (prev_class_reg == CLASS_DRIVE && item.bms_class == CLASS_ENERGIZED) begin
            result.transition_chime = CHIME_EXIT;
        end

        if (!active) begin
            ready_next   = 1'b0;
            armed_next   = 1'b0;
            latched_next = 1'b0;
        end else begin
            if (arm_cond) begin
                if (!armed_reg) begin
                    armed_next     = 1'b1;
                    arm_start_next = now_t;
                end
            end else begin
                armed_next = 1'b0;
            end

            // Differences wrap naturally at the width of the time base.
            elapsed = now_t - arm_start_next;
            held    = armed_next && (elapsed >= TIME_BITS'(cfg.hold_time_ms));

            // One toggle per press: the latch holds until the hold condition drops.
            if (held) begin
                if (!latched_reg) begin
                    ready_next          = !ready_reg;
                    result.toggle_chime = ready_reg ? CHIME_EXIT : CHIME_ENTER;
                    latched_next        = 1'b1;
                end
            end else begin
                latched_next = 1'b0;
            end
        end
        result.ready_to_drive = ready_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_class_reg <= CLASS_OTHER;
            ready_reg      <= 1'b0;
            armed_reg      <= 1'b0;
            latched_reg    <= 1'b0;
            arm_start_reg  <= '0;
        end else if (step) begin
            prev_class_reg <= prev_class_next;
            ready_reg      <= ready_next;
            armed_reg      <= armed_next;
            latched_reg    <= latched_next;
            arm_start_reg  <= arm_start_next;
        end
    end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import rtdi_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int RESET_CYC   = 4;
    localparam int LATENCY     = 2;
    localparam int LONG_STALL  = 300;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int ITEMS_PER_SETTING = 330;
    localparam int IN_FILL     = S_DATA_W - $bits(in_item_t);

    typedef struct {
        in_item_t  stim;
        bit        typed;
        out_item_t want;
    } dir_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    ready_to_drive_interlock DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #CLK_HALF aclk = ~aclk;

    // Interlock state as the predictor sees it.
    logic [BRAKE_W-1:0] brake_thr;
    logic [HOLD_W-1:0]  hold_ms;
    bms_class_t         last_class;
    logic               rtd_q;
    logic               armed_q;
    logic [NOW_W-1:0]   arm_t0;
    logic               latched_q;

    out_item_t pending_results[$];
    int        fail_count = 0;
    int        items_sent = 0;
    int        toggles_seen = 0;
    int        cycle_count = 0;
    bit        sender_gaps = 1'b1;
    bit        sink_gaps = 1'b1;
    bit        long_stall_req = 1'b0;

    // Stimulus generator state for well-formed drive sessions.
    logic [NOW_W-1:0] gen_now;
    bms_class_t       gen_class;
    logic             gen_button;

    function automatic void clear_interlock();
        brake_thr  = BRAKE_THRESHOLD_RESET;
        hold_ms    = HOLD_TIME_RESET;
        last_class = CLASS_OTHER;
        rtd_q      = 1'b0;
        armed_q    = 1'b0;
        arm_t0     = '0;
        latched_q  = 1'b0;
    endfunction

    function automatic out_item_t interlock_next(in_item_t it);
        out_item_t        r;
        logic             arm_cond;
        logic [NOW_W-1:0] held_for;
        r.ready_to_drive   = 1'b0;
        r.transition_chime = CHIME_NONE;
        r.toggle_chime     = CHIME_NONE;
        if (last_class == CLASS_ENERGIZED && it.bms_class == CLASS_DRIVE) begin
            r.transition_chime = CHIME_ENTER;
        end else if (last_class == CLASS_DRIVE && it.bms_class == CLASS_ENERGIZED) begin
            r.transition_chime = CHIME_EXIT;
        end
        last_class = it.bms_class;
        if (it.bms_class != CLASS_ENERGIZED && it.bms_class != CLASS_DRIVE) begin
            rtd_q     = 1'b0;
            armed_q   = 1'b0;
            latched_q = 1'b0;
        end else begin
            arm_cond = it.brake_fresh && it.bms_fresh && it.button_pressed
                       && (it.brake_level > brake_thr);
            if (arm_cond) begin
                if (!armed_q) begin
                    armed_q = 1'b1;
                    arm_t0  = it.now_ms;
                end
            end else begin
                armed_q = 1'b0;
            end
            held_for = it.now_ms - arm_t0;
            if (armed_q && held_for >= NOW_W'(hold_ms)) begin
                if (!latched_q) begin
                    rtd_q = ~rtd_q;
                    r.toggle_chime = rtd_q ? CHIME_ENTER : CHIME_EXIT;
                    latched_q = 1'b1;
                end
            end else begin
                latched_q = 1'b0;
            end
        end
        r.ready_to_drive = rtd_q;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 15);
        if (r < 12) return $urandom_range(1, 3);
        if (r < 15) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic dir_row_t mk_row(bms_class_t cls, logic btn, logic [BRAKE_W-1:0] brake,
                                        logic bf, logic mf, logic [NOW_W-1:0] now,
                                        bit typed, out_item_t want);
        dir_row_t row;
        row.stim.bms_class      = cls;
        row.stim.button_pressed = btn;
        row.stim.brake_level    = brake;
        row.stim.brake_fresh    = bf;
        row.stim.bms_fresh      = mf;
        row.stim.now_ms         = now;
        row.typed = typed;
        row.want  = want;
        return row;
    endfunction

    function automatic in_item_t random_tick();
        in_item_t it;
        int       step;
        int       r;
        step = int'(hold_ms) / 4 + 2;
        if ($urandom_range(0, 63) == 0) begin
            gen_now = $urandom();
        end else begin
            gen_now = gen_now + NOW_W'($urandom_range(0, step));
        end
        if ($urandom_range(0, 9) == 0) begin
            r = $urandom_range(0, 9);
            if (r == 0) gen_class = CLASS_OTHER;
            else if (r == 1) gen_class = CLASS_UNUSED;
            else if (r < 6) gen_class = CLASS_ENERGIZED;
            else gen_class = CLASS_DRIVE;
        end
        if ($urandom_range(0, 5) == 0) gen_button = ~gen_button;
        it.bms_class      = gen_class;
        it.button_pressed = gen_button;
        // Mostly a brake pressed past the threshold, so that the timer arms.
        if (int'(brake_thr) < 16383 && $urandom_range(0, 9) < 7) begin
            it.brake_level = BRAKE_W'($urandom_range(int'(brake_thr) + 1, 16383));
        end else begin
            it.brake_level = BRAKE_W'($urandom_range(0, 16383));
        end
        it.brake_fresh = ($urandom_range(0, 15) != 0);
        it.bms_fresh   = ($urandom_range(0, 15) != 0);
        it.now_ms      = gen_now;
        return it;
    endfunction

    task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
        int        gap;
        out_item_t predicted;
        gap = (sender_gaps && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{IN_FILL{1'b0}}, it};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = interlock_next(it);
        if (predicted.toggle_chime != CHIME_NONE) toggles_seen++;
        pending_results.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    task automatic settle();
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (LATENCY + 2) @(posedge aclk);
    endtask

    task automatic write_settings(input logic [CFG_DATA_W-1:0] thr_val,
                                  input logic [CFG_DATA_W-1:0] hold_val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_BRAKE_THRESHOLD;
        cfg_wdata <= thr_val;
        @(posedge aclk);
        cfg_addr  <= REG_HOLD_TIME;
        cfg_wdata <= hold_val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        brake_thr = thr_val[BRAKE_W-1:0];
        hold_ms   = hold_val;
    endtask

    task automatic check_result(input logic [M_DATA_W-1:0] raw);
        out_item_t got;
        out_item_t want;
        got = out_item_t'(raw[$bits(out_item_t)-1:0]);
        if (pending_results.size() == 0) begin
            $error("result item 0x%0h arrived with none expected", raw);
            fail_count++;
        end else begin
            want = pending_results.pop_front();
            if (got.ready_to_drive !== want.ready_to_drive) begin
                $error("ready_to_drive: expected %0d, got %0d",
                       want.ready_to_drive, got.ready_to_drive);
                fail_count++;
            end
            if (got.transition_chime !== want.transition_chime) begin
                $error("transition_chime: expected %0d, got %0d",
                       want.transition_chime, got.transition_chime);
                fail_count++;
            end
            if (got.toggle_chime !== want.toggle_chime) begin
                $error("toggle_chime: expected %0d, got %0d",
                       want.toggle_chime, got.toggle_chime);
                fail_count++;
            end
        end
    endtask

    initial begin : result_sink
        int hold_off;
        hold_off = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) check_result(m_tdata);
            if (long_stall_req) begin
                long_stall_req = 1'b0;
                hold_off = LONG_STALL;
            end
            if (hold_off > 0) begin
                hold_off--;
                m_tready <= 1'b0;
            end else if (sink_gaps && $urandom_range(0, 3) == 0) begin
                hold_off = pick_gap() - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin : stimulus
        dir_row_t  rows[$];
        out_item_t idle_out;
        out_item_t none_out;
        logic [CFG_DATA_W-1:0] thr_list[6];
        logic [CFG_DATA_W-1:0] hold_list[6];

        clear_interlock();
        none_out.ready_to_drive   = 1'b0;
        none_out.transition_chime = CHIME_NONE;
        none_out.toggle_chime     = CHIME_NONE;
        idle_out = none_out;

        // Directed rows at the reset settings (threshold 1000, hold 1000 ms).
        rows.push_back(mk_row(CLASS_OTHER, 0, 14'd0, 0, 0, 32'd0, 1, idle_out));
        rows.push_back(mk_row(CLASS_UNUSED, 1, 14'h3FFF, 1, 1, 32'hFFFF_FFFF, 1, idle_out));
        // A brake exactly at the threshold must not arm.
        rows.push_back(mk_row(CLASS_ENERGIZED, 1, 14'd1000, 1, 1, 32'd100, 1, idle_out));
        rows.push_back(mk_row(CLASS_ENERGIZED, 1, 14'd1001, 1, 1, 32'd200, 0, none_out));
        rows.push_back(mk_row(CLASS_ENERGIZED, 1, 14'd1001, 1, 1, 32'd1199, 0, none_out));
        rows.push_back(mk_row(CLASS_ENERGIZED, 1, 14'd1001, 1, 1, 32'd1200, 0, none_out));
        rows.push_back(mk_row(CLASS_ENERGIZED, 1, 14'd1001, 1, 1, 32'd5000, 0, none_out));
        rows.push_back(mk_row(CLASS_DRIVE, 1, 14'd1001, 1, 1, 32'd5001, 0, none_out));
        rows.push_back(mk_row(CLASS_ENERGIZED, 1, 14'd1001, 1, 1, 32'd5002, 0, none_out));
        rows.push_back(mk_row(CLASS_ENERGIZED, 0, 14'd1001, 1, 1, 32'd5003, 0, none_out));
        // The hold time is measured across the wrap of the tick counter.
        rows.push_back(mk_row(CLASS_ENERGIZED, 1, 14'd10000, 1, 1, 32'hFFFF_FF00, 0, none_out));
        rows.push_back(mk_row(CLASS_ENERGIZED, 1, 14'd10000, 1, 1, 32'h0000_02F0, 0, none_out));
        rows.push_back(mk_row(CLASS_ENERGIZED, 1, 14'd10000, 0, 1, 32'h0000_0400, 0, none_out));
        rows.push_back(mk_row(CLASS_ENERGIZED, 1, 14'd10000, 1, 0, 32'h0000_0500, 0, none_out));
        rows.push_back(mk_row(CLASS_DRIVE, 1, 14'h3FFF, 1, 1, 32'd10, 0, none_out));
        rows.push_back(mk_row(CLASS_DRIVE, 1, 14'h3FFF, 1, 1, 32'd1010, 0, none_out));
        rows.push_back(mk_row(CLASS_OTHER, 1, 14'h3FFF, 1, 1, 32'd1020, 1, idle_out));
        rows.push_back(mk_row(CLASS_DRIVE, 1, 14'h3FFF, 1, 1, 32'd2000, 0, none_out));
        rows.push_back(mk_row(CLASS_UNUSED, 0, 14'h1555, 1, 1, 32'h5555_5555, 1, idle_out));
        rows.push_back(mk_row(CLASS_ENERGIZED, 1, 14'h2AAA, 1, 1, 32'hAAAA_AAAA, 0, none_out));

        repeat (RESET_CYC) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i]) send_item(rows[i].stim, rows[i].typed, rows[i].want);
        s_tvalid <= 1'b0;
        @(posedge aclk);

        // Settings: zero, maximum hold, a threshold that can never be passed,
        // ordinary values, then back to the reset values.
        thr_list[0] = 16'd0;     hold_list[0] = 16'd0;
        thr_list[1] = 16'd10000; hold_list[1] = 16'd65535;
        thr_list[2] = 16'hFFFF;  hold_list[2] = 16'd1;
        thr_list[3] = CFG_DATA_W'($urandom_range(0, 10000));
        hold_list[3] = CFG_DATA_W'($urandom_range(0, 3000));
        thr_list[4] = 16'd500;   hold_list[4] = 16'd100;
        thr_list[5] = 16'd1000;  hold_list[5] = 16'd1000;

        for (int p = 0; p < 6; p++) begin
            settle();
            write_settings(thr_list[p], hold_list[p]);
            gen_now    = (p % 2 == 0) ? NOW_W'($urandom()) : 32'hFFFF_0000;
            gen_class  = CLASS_ENERGIZED;
            gen_button = 1'b1;
            // The sink holds off for a long stretch while the source keeps
            // offering items, so the block fills and stalls its input.
            if (p == 1) begin
                sender_gaps = 1'b0;
                long_stall_req = 1'b1;
            end
            for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
                if (n % 100 == 50) begin
                    sender_gaps = ($urandom_range(0, 2) != 0);
                    sink_gaps   = ($urandom_range(0, 2) != 0);
                end
                send_item(random_tick(), 1'b0, none_out);
            end
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end

        settle();
        repeat (LATENCY + 8) @(posedge aclk);
        $display("Covered %0d items over 6 register settings plus the reset values,",
                 items_sent);
        $display("with %0d predicted ready-to-drive toggles and wrapped tick times.",
                 toggles_seen);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/rtdi_pkg.sv
design/rtdi_cfg.sv
design/rtdi_core.sv
design/ready_to_drive_interlock.sv
tb/sv/tb_top.sv
